@@ src/brwl_pkg.sv @@
// Shared types, constants and arithmetic helpers for the bounded random walk list.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package brwl_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 4096;
  localparam int unsigned DataW          = 16;
  localparam int unsigned IndexW         = 12;
  localparam int unsigned CfgW           = 32;
  localparam logic [63:0] RNG_SEED       = 64'd88172645463325252;
  localparam int unsigned XsA            = 13;
  localparam int unsigned XsB            = 7;
  localparam int unsigned XsC            = 17;
  localparam logic signed [39:0] HALF_Q16 = 40'sd32768;

  // Sum and fold width, dividend width and divisor width of the remainder unit.
  localparam int unsigned SumW = 36;
  localparam int unsigned DivN = 37;
  localparam int unsigned DivD = 33;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_WALK = 2'd1,
    OP_FILL = 2'd2,
    OP_READ = 2'd3
  } brwl_op_e;

  typedef enum logic [1:0] {
    REG_STEP  = 2'd0,
    REG_LOWER = 2'd1,
    REG_UPPER = 2'd2,
    REG_NONE  = 2'd3
  } brwl_reg_e;

  typedef struct packed {
    logic            start;
    logic [DivN-1:0] dividend;
    logic [DivD-1:0] divisor;
  } brwl_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivD-1:0] rem;
  } brwl_div_rsp_t;

  // Q16.16 truncation toward zero, saturated to 16 bits.
  function automatic logic signed [DataW-1:0] trunc_sat16(input logic signed [39:0] q);
    logic signed [39:0] n;
    logic signed [39:0] mag;
    begin
      mag = -q;
      n = (q >= 0) ? (q >>> 16) : -(mag >>> 16);
      if (n > 40'sd32767) begin
        trunc_sat16 = 16'sh7fff;
      end else if (n < -40'sd32768) begin
        trunc_sat16 = 16'sh8000;
      end else begin
        trunc_sat16 = n[DataW-1:0];
      end
    end
  endfunction

endpackage

@@ src/bounded_random_walk_list_core.sv @@
// Top level of the bounded random walk list: control sequencer, walk datapath and
// config registers. Depends on brwl_pkg, brwl_store, brwl_rng and brwl_rem.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries opcode, index and value; the
//   output channel (out_valid_o/out_ready_i) returns one entry_index/entry_value
//   transaction per input transaction, in order.
//   One item is in work at a time. The store is read, modified and written back
//   through one synchronous memory with registered read data; since the next
//   item is taken only after the write-back, no two accesses overlap.
//   Paths per item: a load or a fixed-limit walk writes at once; a read or an
//   unchanged walk reads the store; a moving walk goes through multiply, sum,
//   fold and round, and through the bit-serial remainder unit when a single
//   reflection is not enough; a fill writes one store entry per cycle.
//   A finished result sits in the output register; a new item is accepted while
//   it waits. If the receiver stalls, the next result waits in the sequencer
//   and input is held off until the output register frees.
//   After reset the block clears the store to zero, one entry per cycle, with
//   in_ready_o low. Write configuration only while no item is in flight; a
//   write applies to the next item.
`timescale 1ns / 1ps
module bounded_random_walk_list_core import brwl_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               opcode_i,
  input  logic [IndexW-1:0]        index_i,
  input  logic signed [DataW-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IndexW-1:0]        entry_index_o,
  output logic signed [DataW-1:0]  entry_value_o
);

  localparam int unsigned AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [16:0] DepthW = 17'(LIST_DEPTH);

  typedef enum logic [8:0] {
    S_SWEEP = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_FOLD  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_RND   = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_MUL   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]        step_q;
  logic signed [CfgW-1:0] lo_q, hi_q;

  logic [IndexW-1:0]       idx_q, idx_d;
  logic signed [DataW-1:0] res_q, res_d;
  logic signed [DataW-1:0] fill_q, fill_d;
  logic                    sweep_out_q, sweep_out_d;
  logic                    walk_q, walk_d;
  logic [AddrW-1:0]        cnt_q, cnt_d;
  logic signed [DataW-1:0] cur_q, cur_d;
  logic signed [64:0]      prod_q, prod_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic signed [SumW-1:0]  fold_q, fold_d;
  logic                    neg_q, neg_d;
  logic [DivD-1:0]         dd_q, dd_d;
  logic [DivD-1:0]         rng_q, rng_d;

  logic                    out_valid_q, out_valid_d;
  logic [IndexW-1:0]       out_idx_q;
  logic signed [DataW-1:0] out_val_q;
  logic                    out_load;

  logic                    mem_we;
  logic [AddrW-1:0]        mem_waddr;
  logic signed [DataW-1:0] mem_wdata;
  logic signed [DataW-1:0] mem_rdata;

  logic          rng_adv;
  logic [63:0]   rng_z;
  brwl_div_req_t div_req;
  brwl_div_rsp_t div_rsp;

  logic                    in_acc;
  logic                    in_range;
  logic signed [DataW-1:0] lo_trunc;
  logic signed [31:0]      rq;
  logic signed [SumW-1:0]  lo_x, hi_x, tup, tdn, xdiff_s;
  logic signed [DivN:0]    xdiff;
  logic [DivD-1:0]         c1, c2;

  brwl_store #(.Depth(LIST_DEPTH), .AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (AddrW'(index_i)),
    .rdata_o (mem_rdata)
  );

  brwl_rng u_rng (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (rng_adv),
    .state_o (rng_z)
  );

  brwl_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 32'd65536;
      lo_q   <= 32'sd0;
      hi_q   <= 32'sd8323072;
    end else if (cfg_we_i) begin
      case (brwl_reg_e'(cfg_idx_i))
        REG_STEP:  step_q <= cfg_wdata_i;
        REG_LOWER: lo_q   <= cfg_wdata_i;
        REG_UPPER: hi_q   <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_range   = {5'd0, index_i} < DepthW;
  assign lo_trunc   = trunc_sat16(40'(lo_q));
  assign rq         = {~rng_z[63], rng_z[62:32]};
  assign lo_x       = SumW'(lo_q);
  assign hi_x       = SumW'(hi_q);
  assign tup        = hi_x + hi_x - sum_q;
  assign tdn        = lo_x + lo_x - sum_q;
  assign xdiff_s    = sum_q - lo_x;
  assign xdiff      = (DivN+1)'(xdiff_s);
  assign c1         = (neg_q && (div_rsp.rem != '0)) ? (dd_q - div_rsp.rem) : div_rsp.rem;
  assign c2         = (c1 >= rng_q) ? (dd_q - c1) : c1;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    res_d       = res_q;
    fill_d      = fill_q;
    sweep_out_d = sweep_out_q;
    walk_d      = walk_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    fold_d      = fold_q;
    neg_d       = neg_q;
    dd_d        = dd_q;
    rng_d       = rng_q;
    mem_we      = 1'b0;
    mem_waddr   = AddrW'(idx_q);
    mem_wdata   = res_q;
    rng_adv     = 1'b0;
    div_req     = '0;

    case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = fill_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == AddrW'(LIST_DEPTH - 1)) begin
          state_d = sweep_out_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          idx_d  = index_i;
          walk_d = 1'b0;
          if (brwl_op_e'(opcode_i) == OP_FILL) begin
            fill_d      = lo_trunc;
            res_d       = lo_trunc;
            idx_d       = '0;
            cnt_d       = '0;
            sweep_out_d = 1'b1;
            state_d     = S_SWEEP;
          end else if (!in_range) begin
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            case (brwl_op_e'(opcode_i))
              OP_LOAD: begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(index_i);
                mem_wdata = value_i;
                res_d     = value_i;
                state_d   = S_DONE;
              end
              OP_WALK: begin
                if (lo_q == hi_q) begin
                  mem_we    = 1'b1;
                  mem_waddr = AddrW'(index_i);
                  mem_wdata = lo_trunc;
                  res_d     = lo_trunc;
                  state_d   = S_DONE;
                end else begin
                  if ((lo_q < hi_q) && (step_q != '0)) begin
                    rng_adv = 1'b1;
                    walk_d  = 1'b1;
                  end
                  state_d = S_RD;
                end
              end
              default: state_d = S_RD;
            endcase
          end
        end
      end
      S_RD: begin
        cur_d = mem_rdata;
        res_d = mem_rdata;
        state_d = walk_q ? S_MUL : S_DONE;
      end
      S_MUL: begin
        prod_d  = 65'(rq) * $signed({33'd0, step_q});
        state_d = S_SUM;
      end
      S_SUM: begin
        sum_d   = SumW'($signed({cur_q, 16'd0})) + SumW'($signed(prod_q[64:31]));
        state_d = S_FOLD;
      end
      S_FOLD: begin
        state_d = S_RND;
        if (sum_q >= hi_x) begin
          fold_d = tup;
          if (tup < lo_x) begin
            state_d = S_DIV;
          end
        end else if (sum_q < lo_x) begin
          fold_d = tdn;
          if (tdn >= hi_x) begin
            state_d = S_DIV;
          end
        end else begin
          fold_d = sum_q;
        end
        if (state_d == S_DIV) begin
          // Floored remainder of (s - lo) over twice the range, on the magnitude.
          neg_d            = xdiff[DivN];
          rng_d            = DivD'(hi_x - lo_x);
          dd_d             = DivD'(hi_x - lo_x) << 1;
          div_req.start    = 1'b1;
          div_req.dividend = xdiff[DivN] ? DivN'(-xdiff) : xdiff[DivN-1:0];
          div_req.divisor  = DivD'(hi_x - lo_x) << 1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fold_d  = SumW'($signed({1'b0, c2})) + lo_x;
          state_d = S_RND;
        end
      end
      S_RND: begin
        mem_we    = 1'b1;
        mem_wdata = trunc_sat16(40'(fold_q) + HALF_Q16);
        res_d     = mem_wdata;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      cnt_q       <= '0;
      fill_q      <= '0;
      sweep_out_q <= 1'b0;
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      sweep_out_q <= sweep_out_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    res_q  <= res_d;
    cur_q  <= cur_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    fold_q <= fold_d;
    neg_q  <= neg_d;
    dd_q   <= dd_d;
    rng_q  <= rng_d;
    if (out_load) begin
      out_idx_q <= idx_q;
      out_val_q <= res_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = out_idx_q;
  assign entry_value_o = out_val_q;

endmodule

@@ src/brwl_rng.sv @@
// 64-bit xorshift generator (shifts 13, 7, 17) holding its state in a register.
// Depends on brwl_pkg.
`timescale 1ns / 1ps
module brwl_rng import brwl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  output logic [63:0] state_o
);

  logic [63:0] state_q, state_d;
  logic [63:0] z1, z2;

  always_comb begin
    z1 = state_q ^ (state_q << XsA);
    z2 = z1 ^ (z1 >> XsB);
    state_d = adv_i ? (z2 ^ (z2 << XsC)) : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RNG_SEED;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

@@ src/brwl_rem.sv @@
// Restoring remainder unit: one dividend bit per cycle over a DivN-bit dividend.
// Depends on brwl_pkg.
`timescale 1ns / 1ps
module brwl_rem import brwl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  brwl_div_req_t req_i,
  output brwl_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivN + 1);

  logic [DivN-1:0] num_q;
  logic [DivD-1:0] den_q;
  logic [DivD:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DivD:0]   trial;
  logic            done_q;

  assign trial = {rem_q[DivD-1:0], num_q[DivN-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivN - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= (trial >= {1'b0, den_q}) ? (trial - {1'b0, den_q}) : trial;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[DivD-1:0];

endmodule

@@ src/brwl_store.sv @@
// Entry store: single write port, one read port with registered read data.
// Depends on brwl_pkg.
`timescale 1ns / 1ps
module brwl_store import brwl_pkg::*; #(
  parameter int unsigned Depth = LIST_DEPTH_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [DataW-1:0] rdata_o
);

  logic signed [DataW-1:0] mem_q [Depth];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/brwl_checker.sv @@
// Port-level checks for bounded_random_walk_list_core, bound to the top level.
// Depends on brwl_pkg and the top level's port list.
`timescale 1ns / 1ps
module brwl_checker import brwl_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [IndexW-1:0]       entry_index_o,
  input logic signed [DataW-1:0] entry_value_o
);

  // One item in work at a time: input closes right after a transaction.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(entry_index_o) && $stable(entry_value_o)))
    else $error("stalled result changed or dropped");

  // Store clearing holds off input when reset releases.
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input open during store clearing");

endmodule

bind bounded_random_walk_list_core brwl_checker u_brwl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .entry_index_o (entry_index_o),
  .entry_value_o (entry_value_o)
);

@@ sim/bounded_random_walk_list_checker.sv @@
// Checker for the bounded random walk list: tracks config writes and input
// transactions, predicts each result and compares the output channel against it.
// Depends on brwl_pkg.
`timescale 1ns / 1ps
module bounded_random_walk_list_checker import brwl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [1:0]              opcode_i,
  input  logic [IndexW-1:0]       index_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [IndexW-1:0]       entry_index_i,
  input  logic signed [DataW-1:0] entry_value_i,
  output int                      mismatch_cnt_o,
  output int                      pending_cnt_o
);

  typedef struct packed {
    logic [IndexW-1:0]       idx;
    logic signed [DataW-1:0] val;
  } entry_result_t;

  logic signed [DataW-1:0] entry_mirror [LIST_DEPTH_DEF];
  logic [63:0]             walk_rng;
  logic [31:0]             step_q;
  longint                  lower_q;
  longint                  upper_q;
  entry_result_t           expected_entries [$];

  function automatic logic signed [DataW-1:0] round_to_entry(longint q);
    longint n;
    n = (q >= 0) ? (q >>> 16) : -((-q) >>> 16);
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n[DataW-1:0];
  endfunction

  function automatic longint reflect_into_limits(longint s, longint lo, longint hi);
    longint t, span, span2, c;
    if (s >= hi) begin
      t = hi + hi - s;
      if (t >= lo) return t;
    end else if (s < lo) begin
      t = lo + lo - s;
      if (t < hi) return t;
    end else begin
      return s;
    end
    span = hi - lo;
    span2 = span + span;
    c = (s - lo) % span2;
    if (c < 0) c += span2;
    if (c >= span) c = span2 - c;
    return c + lo;
  endfunction

  function automatic logic signed [DataW-1:0] walked_entry(logic signed [DataW-1:0] cur);
    logic [63:0] z;
    longint      rq, prod, delta, sum;
    if (lower_q > upper_q) return cur;
    if (lower_q == upper_q) return round_to_entry(lower_q);
    if (step_q == 0) return cur;
    z = walk_rng;
    z ^= z << XsA;
    z ^= z >> XsB;
    z ^= z << XsC;
    walk_rng = z;
    rq = longint'({32'b0, z[63:32]}) - 64'sh8000_0000;
    prod = rq * longint'({32'b0, step_q});
    delta = prod >>> 31;
    sum = longint'(cur) * 65536 + delta;
    return round_to_entry(reflect_into_limits(sum, lower_q, upper_q) + 32768);
  endfunction

  function automatic entry_result_t predict_entry(brwl_op_e op, logic [IndexW-1:0] idx,
                                                  logic signed [DataW-1:0] val);
    entry_result_t r;
    r.idx = idx;
    r.val = '0;
    if (op == OP_FILL) begin
      r.idx = '0;
      r.val = round_to_entry(lower_q);
      foreach (entry_mirror[i]) entry_mirror[i] = r.val;
    end else if (idx < LIST_DEPTH_DEF) begin
      if (op == OP_LOAD) entry_mirror[idx] = val;
      else if (op == OP_WALK) entry_mirror[idx] = walked_entry(entry_mirror[idx]);
      r.val = entry_mirror[idx];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    entry_result_t exp_r;
    if (!rst_ni) begin
      foreach (entry_mirror[i]) entry_mirror[i] = '0;
      walk_rng = RNG_SEED;
      step_q = 32'd65536;
      lower_q = 0;
      upper_q = 8323072;
      expected_entries.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (brwl_reg_e'(cfg_idx_i))
          REG_STEP:  step_q = cfg_wdata_i;
          REG_LOWER: lower_q = longint'($signed(cfg_wdata_i));
          REG_UPPER: upper_q = longint'($signed(cfg_wdata_i));
          default: ;
        endcase
      end
      // retire before push: a result never belongs to the item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_entries.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("unexpected result: index %0d value %0d", entry_index_i, entry_value_i);
        end else begin
          exp_r = expected_entries.pop_front();
          if (exp_r.idx !== entry_index_i || exp_r.val !== entry_value_i) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display("mismatch: expected index %0d value %0d, got index %0d value %0d",
                       exp_r.idx, exp_r.val, entry_index_i, entry_value_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_entries.push_back(predict_entry(brwl_op_e'(opcode_i), index_i, value_i));
      pending_cnt_o = expected_entries.size();
    end
  end

endmodule

@@ sim/bounded_random_walk_list_core_tb.sv @@
// Testbench top for bounded_random_walk_list_core: clock, reset, stimulus and verdict.
// Depends on brwl_pkg, the core RTL and bounded_random_walk_list_checker.
`timescale 1ns / 1ps
module bounded_random_walk_list_core_tb;
  import brwl_pkg::*;

  localparam int CycleLimit = 1_000_000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_idx_i = '0;
  logic [CfgW-1:0]         cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              opcode_i = '0;
  logic [IndexW-1:0]       index_i = '0;
  logic signed [DataW-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [IndexW-1:0]       entry_index_o;
  logic signed [DataW-1:0] entry_value_o;
  int                      mismatch_cnt;
  int                      pending_cnt;
  int                      holdoff_req = 0;
  int                      cycle_cnt = 0;

  always #10 clk_i = ~clk_i;

  bounded_random_walk_list_core dut (.*);

  bounded_random_walk_list_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .index_i, .value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .entry_index_i(entry_index_o),
    .entry_value_i(entry_value_o), .mismatch_cnt_o(mismatch_cnt), .pending_cnt_o(pending_cnt)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: changing stall pattern, plus long hold-offs on request.
  initial begin
    int mode;
    int run;
    mode = 0;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req > 0) begin
        out_ready_i = 1'b0;
        repeat (holdoff_req - 1) @(negedge clk_i);
        holdoff_req = 0;
      end else begin
        if (run == 0) begin
          mode = $urandom_range(0, 2);
          run = $urandom_range(20, 200);
        end
        run--;
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          default: out_ready_i = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(brwl_reg_e r, logic [CfgW-1:0] d);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = r;
    cfg_wdata_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_item(brwl_op_e op, logic [IndexW-1:0] idx, logic signed [DataW-1:0] val,
                           int gap);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i = op;
    index_i = idx;
    value_i = val;
    do @(posedge clk_i); while (!in_ready_o);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic random_limits();
    logic [31:0] lo, hi;
    case ($urandom_range(0, 5))
      0: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
      1: begin lo = $urandom; hi = lo; end
      2: begin lo = $urandom; hi = $urandom; end
      3: begin
        lo = $urandom_range(0, 32'h00ff_ffff);
        hi = lo + $urandom_range(1, 32'h0004_0000);
      end
      default: begin
        lo = -$urandom_range(0, 32'h0100_0000);
        hi = $urandom_range(0, 32'h0100_0000);
      end
    endcase
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, hi);
  endtask

  initial begin
    int burst;
    int gap;
    int pick;
    brwl_op_e op;
    logic [IndexW-1:0] idx;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every opcode, fold corners.
    send_item(OP_LOAD, 12'd0, -16'sd32768, 0);
    send_item(OP_LOAD, 12'd4095, 16'sd32767, 0);
    send_item(OP_LOAD, 12'd5, 16'sd0, 0);
    send_item(OP_READ, 12'd0, 16'sh5555, 0);
    send_item(OP_READ, 12'd4095, 16'shaaaa, 0);
    send_item(OP_WALK, 12'd5, 16'sd0, 0);
    send_item(OP_WALK, 12'd4095, 16'sd0, 0);
    send_item(OP_WALK, 12'd0, 16'sd0, 1);
    send_item(OP_FILL, 12'hfff, -16'sd1, 1);
    send_item(OP_READ, 12'd7, 16'sd0, 1);
    drain();
    write_reg(REG_LOWER, 32'h0005_8000);   // equal limits
    write_reg(REG_UPPER, 32'h0005_8000);
    write_reg(REG_NONE, 32'hffff_ffff);
    send_item(OP_WALK, 12'd9, 16'sd0, 1);
    drain();
    write_reg(REG_UPPER, 32'h0001_0000);   // crossed limits
    send_item(OP_WALK, 12'd9, 16'sd0, 1);
    drain();
    write_reg(REG_STEP, 32'd0);            // zero step
    write_reg(REG_LOWER, 32'hfff0_0000);
    send_item(OP_WALK, 12'd9, 16'sd0, 1);
    drain();
    // top of range: rounding lands on 32768 and saturates
    write_reg(REG_STEP, 32'hffff_ffff);
    write_reg(REG_LOWER, 32'h7fff_8000);
    write_reg(REG_UPPER, 32'h7fff_ffff);
    send_item(OP_LOAD, 12'd3, 16'sd32767, 0);
    send_item(OP_WALK, 12'd3, 16'sd0, 0);
    send_item(OP_WALK, 12'd3, 16'sd0, 1);
    drain();
    write_reg(REG_LOWER, 32'h8000_0000);
    send_item(OP_WALK, 12'd0, 16'sd0, 0);
    send_item(OP_WALK, 12'd4095, 16'sd0, 0);
    send_item(OP_FILL, 12'd0, 16'sd0, 1);
    drain();

    // Random phases: fresh config, then a mix of items in bursts.
    for (int ph = 0; ph < 9; ph++) begin
      pick = $urandom_range(0, 9);
      write_reg(REG_STEP, pick == 0 ? 32'd0 : pick < 4 ? $urandom_range(1, 32'h0004_0000)
                        : pick == 4 ? 32'hffff_ffff : $urandom);
      random_limits();
      if (ph == 4) holdoff_req = 400;
      burst = 0;
      for (int n = 0; n < 150; n++) begin
        pick = $urandom_range(0, 199);
        op = pick < 2 ? OP_FILL : pick < 100 ? OP_WALK : pick < 150 ? OP_LOAD : OP_READ;
        idx = ($urandom_range(0, 3) == 0) ? IndexW'($urandom) : IndexW'($urandom_range(0, 15));
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          gap = (ph == 4 && n < 40) ? 0 : $urandom_range(0, 6);
        end
        burst--;
        send_item(op, idx, DataW'($urandom), burst == 0 ? gap : 0);
      end
      drain();
    end

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
